// ----- rtl/core/cpu_alu_and_flags_unit_macros.svh -----
// Assertion macros for the ALU and flags unit checker.
// Depends on nothing; included by the checker file.
`ifndef CPU_ALU_AND_FLAGS_UNIT_MACROS_SVH
`define CPU_ALU_AND_FLAGS_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CAFU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cafu check failed");

// next-cycle implication, disabled during reset
`define CAFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cafu check failed");

`endif

// ----- rtl/core/cafu_pkg.sv -----
// Types and op codes shared by the ALU and flags unit.
// No dependencies.
package cafu_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RRC   = 5'd11,
        OP_RL    = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SWAP  = 5'd16,
        OP_SRL   = 5'd17,
        OP_BIT   = 5'd18,
        OP_RES   = 5'd19,
        OP_SET   = 5'd20,
        OP_ADD16 = 5'd21,
        OP_CPL   = 5'd22,
        OP_SCF   = 5'd23,
        OP_CCF   = 5'd24
    } t_alu_op;

    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] lhs;
        logic [15:0] rhs;
        logic [2:0]  bit_index;
        logic        accum_form;
    } t_alu_in;

    typedef struct packed {
        logic [15:0] result;
        logic        writes_back;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_carry_flag;
        logic        carry_flag;
    } t_alu_out;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

endpackage

// ----- rtl/core/cafu_alu.sv -----
// Combinational datapath: one operation on operands and held flags.
// Depends on cafu_pkg.
module cafu_alu (
    input  cafu_pkg::t_alu_in  i_item,
    input  cafu_pkg::t_flags   i_flags,
    output cafu_pkg::t_alu_out o_item
);
    import cafu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        k_add;
    logic        k_sub;
    logic [8:0]  sum8;
    logic [4:0]  sum4;
    logic [8:0]  dif8;
    logic [4:0]  dif4;
    logic [16:0] sum16;
    logic [12:0] sum12;
    logic [7:0]  bmask;
    logic [15:0] r;
    logic        wb;
    t_flags      f;
    logic        acc_z;

    assign a     = i_item.lhs[7:0];
    assign b     = i_item.rhs[7:0];
    assign k_add = (i_item.op == OP_ADC) ? i_flags.c : 1'b0;
    assign k_sub = (i_item.op == OP_SBC) ? i_flags.c : 1'b0;
    assign sum8  = {1'b0, a} + {1'b0, b} + {8'd0, k_add};
    assign sum4  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k_add};
    assign dif8  = {1'b0, a} - {1'b0, b} - {8'd0, k_sub};
    assign dif4  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, k_sub};
    assign sum16 = {1'b0, i_item.lhs} + {1'b0, i_item.rhs};
    assign sum12 = {1'b0, i_item.lhs[11:0]} + {1'b0, i_item.rhs[11:0]};
    assign bmask = 8'd1 << i_item.bit_index;
    assign acc_z = i_item.accum_form;

    always_comb begin
        r  = 16'd0;
        wb = 1'b1;
        f  = i_flags;
        case (i_item.op)
            OP_ADD, OP_ADC: begin
                r[7:0] = sum8[7:0];
                f = '{z: (sum8[7:0] == 8'd0), n: 1'b0, h: sum4[4], c: sum8[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                r[7:0] = dif8[7:0];
                f = '{z: (dif8[7:0] == 8'd0), n: 1'b1, h: dif4[4], c: dif8[8]};
                wb = (i_item.op != OP_CP);
            end
            OP_AND: begin
                r[7:0] = a & b;
                f = '{z: ((a & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_XOR: begin
                r[7:0] = a ^ b;
                f = '{z: ((a ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_OR: begin
                r[7:0] = a | b;
                f = '{z: ((a | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_INC: begin
                r[7:0] = a + 8'd1;
                f.z = (a == 8'hFF);
                f.n = 1'b0;
                f.h = (a[3:0] == 4'hF);
            end
            OP_DEC: begin
                r[7:0] = a - 8'd1;
                f.z = (a == 8'h01);
                f.n = 1'b1;
                f.h = (a[3:0] == 4'h0);
            end
            OP_RLC: begin
                r[7:0] = {a[6:0], a[7]};
                f = '{z: !acc_z && (a == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_RRC: begin
                r[7:0] = {a[0], a[7:1]};
                f = '{z: !acc_z && (a == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_RL: begin
                r[7:0] = {a[6:0], i_flags.c};
                f = '{z: !acc_z && ({a[6:0], i_flags.c} == 8'd0), n: 1'b0, h: 1'b0,
                      c: a[7]};
            end
            OP_RR: begin
                r[7:0] = {i_flags.c, a[7:1]};
                f = '{z: !acc_z && ({i_flags.c, a[7:1]} == 8'd0), n: 1'b0, h: 1'b0,
                      c: a[0]};
            end
            OP_SLA: begin
                r[7:0] = {a[6:0], 1'b0};
                f = '{z: (a[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_SRA: begin
                r[7:0] = {a[7], a[7:1]};
                f = '{z: (a[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_SRL: begin
                r[7:0] = {1'b0, a[7:1]};
                f = '{z: (a[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_SWAP: begin
                r[7:0] = {a[3:0], a[7:4]};
                f = '{z: (a == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_BIT: begin
                r[7:0] = a;
                wb = 1'b0;
                f.z = ((a & bmask) == 8'd0);
                f.n = 1'b0;
                f.h = 1'b1;
            end
            OP_RES: begin
                r[7:0] = a & ~bmask;
            end
            OP_SET: begin
                r[7:0] = a | bmask;
            end
            OP_ADD16: begin
                r = sum16[15:0];
                f.n = 1'b0;
                f.h = sum12[12];
                f.c = sum16[16];
            end
            OP_CPL: begin
                r[7:0] = ~a;
                f.n = 1'b1;
                f.h = 1'b1;
            end
            OP_SCF: begin
                wb = 1'b0;
                f.n = 1'b0;
                f.h = 1'b0;
                f.c = 1'b1;
            end
            OP_CCF: begin
                wb = 1'b0;
                f.n = 1'b0;
                f.h = 1'b0;
                f.c = !i_flags.c;
            end
            default: begin
                wb = 1'b0;
            end
        endcase
    end

    assign o_item = '{result: r, writes_back: wb, zero_flag: f.z, subtract_flag: f.n,
                      half_carry_flag: f.h, carry_flag: f.c};

endmodule

// ----- rtl/core/cpu_alu_and_flags_unit.sv -----
// Top level of the 8-bit ALU with its Z/N/H/C flag register.
// Depends on cafu_pkg and cafu_alu.
//
// Input channel: i_in_valid / o_in_stall carry one operation transaction
// (op, lhs, rhs, bit_index, accum_form) in i_in_data.
// Output channel: o_out_valid / i_out_stall carry one result transaction
// (result, writes_back and the four new flags) in o_out_data.
// Every operation gives exactly one result, in order.
// Path: an accepted transaction is held in one input register, then goes
// through the datapath and the flag update into the result register,
// which drives the output.
// Throughput: one transaction per cycle while the receiver does not stall.
// The flag register is written as a transaction moves into the result
// register, so the next operation sees the flags of the one before it
// with no bubble.
// Reset clears both valid bits and the flags to zero.
// When the receiver stalls, the result register holds; one more transaction
// waits in the input register, after which o_in_stall rises.
module cpu_alu_and_flags_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cafu_pkg::t_alu_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cafu_pkg::t_alu_out o_out_data
);
    import cafu_pkg::*;

    logic     r_in_valid;
    logic     n_in_valid;
    t_alu_in  r_in;
    t_alu_in  n_in;
    logic     r_out_valid;
    logic     n_out_valid;
    t_alu_out r_out;
    t_alu_out n_out;
    t_flags   r_flags;
    t_flags   n_flags;
    t_alu_out alu_res;
    logic     out_free;
    logic     advance;
    logic     take;

    cafu_alu u_alu (
        .i_item  (r_in),
        .i_flags (r_flags),
        .o_item  (alu_res)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in        = r_in;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_flags     = r_flags;
        if (out_free) begin
            n_out_valid = r_in_valid;
        end
        if (advance) begin
            n_out   = alu_res;
            n_flags = '{z: alu_res.zero_flag, n: alu_res.subtract_flag,
                        h: alu_res.half_carry_flag, c: alu_res.carry_flag};
        end
        if (!o_in_stall) begin
            n_in_valid = i_in_valid;
        end
        if (take) begin
            n_in = i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_flags     <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/cafu_checker.sv -----
// Port-level checks for the ALU and flags unit, bound to the top level.
// Depends on cafu_pkg and cpu_alu_and_flags_unit_macros.svh.
`include "cpu_alu_and_flags_unit_macros.svh"

module cafu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input cafu_pkg::t_alu_in  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cafu_pkg::t_alu_out o_out_data
);
    import cafu_pkg::*;

    `CAFU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `CAFU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    `CAFU_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `CAFU_ASSERT_NOW(a_discard_narrow, i_clk, i_rst_n, o_out_valid && !o_out_data.writes_back, o_out_data.result[15:8] == 8'd0)

endmodule

bind cpu_alu_and_flags_unit cafu_checker u_cafu_checker (.*);

// ----- tb/sv/cpu_alu_and_flags_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cpu_alu_and_flags_unit: directed corner operations, then random
// ones, scored against a flag-tracking predictor under random input gaps and output stalls.
// Depends on cafu_pkg and the unit's RTL.
module cpu_alu_and_flags_unit_test;
    import cafu_pkg::*;

    localparam logic [4:0] OP_FIRST_UNUSED = 5'd25;
    localparam logic [4:0] OP_LAST_UNUSED  = 5'd31;
    localparam int unsigned RANDOM_OPS     = 1450;

    class alu_flag_scoreboard;
        t_flags      held_flags;
        t_alu_out    pending_results[$];
        int unsigned mismatches;
        int unsigned ops_noted;
        int unsigned results_checked;

        function new();
            held_flags      = '0;
            mismatches      = 0;
            ops_noted       = 0;
            results_checked = 0;
        endfunction

        function void note_operation(t_alu_in x);
            int unsigned a, b, a16, b16, k, t, r, idx;
            logic        wb, out_bit;
            t_flags      f;
            t_alu_out    o;
            f   = held_flags;
            a16 = x.lhs;
            b16 = x.rhs;
            a   = a16 & 'hFF;
            b   = b16 & 'hFF;
            idx = x.bit_index;
            r   = 0;
            wb  = 1'b1;
            case (x.op)
                OP_ADD, OP_ADC: begin
                    k   = (x.op == OP_ADC && f.c) ? 1 : 0;
                    t   = a + b + k;
                    r   = t & 'hFF;
                    f.z = (r == 0);
                    f.n = 1'b0;
                    f.h = (((a & 'hF) + (b & 'hF) + k) & 'h10) != 0;
                    f.c = t > 'hFF;
                end
                OP_SUB, OP_SBC, OP_CP: begin
                    k   = (x.op == OP_SBC && f.c) ? 1 : 0;
                    r   = (a - b - k) & 'hFF;
                    f.z = (r == 0);
                    f.n = 1'b1;
                    f.h = (a & 'hF) < (b & 'hF) + k;
                    f.c = a < b + k;
                    wb  = (x.op != OP_CP);
                end
                OP_AND: begin
                    r = a & b;
                    f = '{z: (r == 0), n: 1'b0, h: 1'b1, c: 1'b0};
                end
                OP_XOR: begin
                    r = a ^ b;
                    f = '{z: (r == 0), n: 1'b0, h: 1'b0, c: 1'b0};
                end
                OP_OR: begin
                    r = a | b;
                    f = '{z: (r == 0), n: 1'b0, h: 1'b0, c: 1'b0};
                end
                OP_INC: begin
                    r   = (a + 1) & 'hFF;
                    f.z = (r == 0);
                    f.n = 1'b0;
                    f.h = (a & 'hF) == 'hF;
                end
                OP_DEC: begin
                    r   = (a - 1) & 'hFF;
                    f.z = (r == 0);
                    f.n = 1'b1;
                    f.h = (a & 'hF) == 0;
                end
                OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
                    case (x.op)
                        OP_RLC: begin
                            out_bit = a[7];
                            r = ((a << 1) | (out_bit ? 1 : 0)) & 'hFF;
                        end
                        OP_RRC: begin
                            out_bit = a[0];
                            r = (a >> 1) | (out_bit ? 'h80 : 0);
                        end
                        OP_RL: begin
                            out_bit = a[7];
                            r = ((a << 1) | (f.c ? 1 : 0)) & 'hFF;
                        end
                        OP_RR: begin
                            out_bit = a[0];
                            r = (a >> 1) | (f.c ? 'h80 : 0);
                        end
                        OP_SLA: begin
                            out_bit = a[7];
                            r = (a << 1) & 'hFF;
                        end
                        OP_SRA: begin
                            out_bit = a[0];
                            r = (a >> 1) | (a & 'h80);
                        end
                        default: begin
                            out_bit = a[0];
                            r = a >> 1;
                        end
                    endcase
                    f.z = (x.accum_form && x.op inside {OP_RLC, OP_RRC, OP_RL, OP_RR}) ?
                          1'b0 : (r == 0);
                    f.n = 1'b0;
                    f.h = 1'b0;
                    f.c = out_bit;
                end
                OP_SWAP: begin
                    r = ((a >> 4) | (a << 4)) & 'hFF;
                    f = '{z: (r == 0), n: 1'b0, h: 1'b0, c: 1'b0};
                end
                OP_BIT: begin
                    r   = a;
                    wb  = 1'b0;
                    f.z = ((a >> idx) & 1) == 0;
                    f.n = 1'b0;
                    f.h = 1'b1;
                end
                OP_RES: r = a & ~(1 << idx) & 'hFF;
                OP_SET: r = (a | (1 << idx)) & 'hFF;
                OP_ADD16: begin
                    t   = a16 + b16;
                    r   = t & 'hFFFF;
                    f.n = 1'b0;
                    f.h = (((a16 & 'hFFF) + (b16 & 'hFFF)) & 'h1000) != 0;
                    f.c = t > 'hFFFF;
                end
                OP_CPL: begin
                    r   = ~a & 'hFF;
                    f.n = 1'b1;
                    f.h = 1'b1;
                end
                OP_SCF: begin
                    wb  = 1'b0;
                    f.n = 1'b0;
                    f.h = 1'b0;
                    f.c = 1'b1;
                end
                OP_CCF: begin
                    wb  = 1'b0;
                    f.n = 1'b0;
                    f.h = 1'b0;
                    f.c = ~f.c;
                end
                default: wb = 1'b0;
            endcase
            held_flags        = f;
            o.result          = r[15:0];
            o.writes_back     = wb;
            o.zero_flag       = f.z;
            o.subtract_flag   = f.n;
            o.half_carry_flag = f.h;
            o.carry_flag      = f.c;
            pending_results.push_back(o);
            ops_noted++;
        endfunction

        function void check_result(t_alu_out got);
            t_alu_out exp;
            if (pending_results.size() == 0) begin
                $error("result transaction with no operation pending: %h", got);
                mismatches++;
            end else begin
                exp = pending_results.pop_front();
                results_checked++;
                if (got.result !== exp.result) begin
                    $error("result: expected %h, got %h", exp.result, got.result);
                    mismatches++;
                end
                if (got.writes_back !== exp.writes_back) begin
                    $error("writes_back: expected %b, got %b", exp.writes_back, got.writes_back);
                    mismatches++;
                end
                if (got.zero_flag !== exp.zero_flag) begin
                    $error("zero_flag: expected %b, got %b", exp.zero_flag, got.zero_flag);
                    mismatches++;
                end
                if (got.subtract_flag !== exp.subtract_flag) begin
                    $error("subtract_flag: expected %b, got %b",
                           exp.subtract_flag, got.subtract_flag);
                    mismatches++;
                end
                if (got.half_carry_flag !== exp.half_carry_flag) begin
                    $error("half_carry_flag: expected %b, got %b",
                           exp.half_carry_flag, got.half_carry_flag);
                    mismatches++;
                end
                if (got.carry_flag !== exp.carry_flag) begin
                    $error("carry_flag: expected %b, got %b", exp.carry_flag, got.carry_flag);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_alu_in  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_alu_out o_out_data;

    alu_flag_scoreboard alu_board;
    logic               quiet_phase = 1'b0;

    cpu_alu_and_flags_unit u_dut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .o_in_stall,
        .i_in_data,
        .o_out_valid,
        .i_out_stall,
        .o_out_data
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 9))
            0: v[7:0]  = 8'h00;
            1: v[7:0]  = 8'hFF;
            2: v[3:0]  = 4'hF;
            3: v[11:0] = 12'hFFF;
            4: v       = 16'hFFFF;
            5: v       = 16'h0000;
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_alu_in make_op(logic [4:0] op, logic [15:0] lhs, logic [15:0] rhs,
                                        logic [2:0] idx, logic acc);
        t_alu_in x;
        x.op         = op;
        x.lhs        = lhs;
        x.rhs        = rhs;
        x.bit_index  = idx;
        x.accum_form = acc;
        return x;
    endfunction

    function automatic t_alu_in random_operation();
        logic [4:0] op;
        if ($urandom_range(0, 99) < 4) op = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        else op = 5'($urandom_range(OP_ADD, OP_CCF));
        return make_op(op, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
    endfunction

    task automatic send_operation(input t_alu_in op_item, input int unsigned gap);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op_item;
        do @(posedge i_clk); while (o_in_stall);
        alu_board.note_operation(op_item);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (alu_board.pending_results.size() != 0);
    endtask

    // stall the result side in random bursts; hold off entirely during quiet phases
    initial begin
        forever begin
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 8) + (($urandom_range(0, 19) == 0) ? 100 : 0))
                @(posedge i_clk);
            if (!quiet_phase) begin
                i_out_stall <= 1'b1;
                repeat (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) :
                        $urandom_range(1, 4))
                    @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            alu_board.check_result(o_out_data);
        end
    end

    initial begin
        #20_000_000;
        $display("Timed out waiting for result transactions");
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned n;
        alu_board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_operation(make_op(OP_SCF,   16'h0000, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_ADC,   16'hFFFF, 16'hFF00, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_SBC,   16'h0000, 16'h00FF, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_ADD,   16'h000F, 16'h0001, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_SUB,   16'h0010, 16'h0001, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_CP,    16'h0042, 16'h0042, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_AND,   16'h00FF, 16'hFF00, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_XOR,   16'h00FF, 16'h00FF, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_OR,    16'h0080, 16'h0001, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_INC,   16'hAAFF, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_DEC,   16'h0000, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_RLC,   16'h0080, 16'h0000, 3'd0, 1'b1), pick_gap());
        send_operation(make_op(OP_RRC,   16'h0001, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_RL,    16'h0080, 16'hFFFF, 3'd0, 1'b1), pick_gap());
        send_operation(make_op(OP_RR,    16'h0001, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_SLA,   16'h0080, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_SRA,   16'h0081, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_SWAP,  16'h00F0, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_SRL,   16'h0001, 16'h0000, 3'd0, 1'b1), pick_gap());
        send_operation(make_op(OP_BIT,   16'h007F, 16'h0000, 3'd7, 1'b0), pick_gap());
        send_operation(make_op(OP_RES,   16'h00FF, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_SET,   16'h0000, 16'h0000, 3'd7, 1'b0), pick_gap());
        send_operation(make_op(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_CPL,   16'h005A, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_CCF,   16'h0000, 16'h0000, 3'd0, 1'b0), pick_gap());
        send_operation(make_op(OP_LAST_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1), pick_gap());
        wait_for_drain();

        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % 100 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
            if (n % 400 == 399) wait_for_drain();
            send_operation(random_operation(), pick_gap());
        end

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d results against %0d operations: directed corners of every op code,",
                 alu_board.results_checked, alu_board.ops_noted);
        $display("then random operands and codes (unused ones too) under gaps, stalls and drains");
        if (alu_board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
